/* design/fihfo_pkg.sv */
// Shared constants for the fade-in / hold / fade-out envelope timer.
package fihfo_pkg;

    localparam int CNT_W = 32;  // elapsed counters and phase lengths
    localparam int OPA_W = 16;  // opacity fraction
    localparam int DLT_W = 16;  // tick delta
    localparam int PH_W  = 2;
    localparam int IDX_W = 2;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [OPA_W-1:0] t_opa;
    typedef logic [PH_W-1:0]  t_phase;
    typedef logic [IDX_W-1:0] t_idx;

    localparam t_phase PH_FADE_IN  = 2'd0;
    localparam t_phase PH_HOLD     = 2'd1;
    localparam t_phase PH_FADE_OUT = 2'd2;
    localparam t_phase PH_DONE     = 2'd3;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam t_idx REG_FADE_IN_TIME  = 2'd0;
    localparam t_idx REG_HOLD_TIME     = 2'd1;
    localparam t_idx REG_FADE_OUT_TIME = 2'd2;
    localparam t_idx REG_LOOP_ENABLE   = 2'd3;

    localparam t_opa OPA_FULL = {OPA_W{1'b1}};
    localparam t_opa OPA_ZERO = '0;
    localparam t_cnt CNT_MAX  = {CNT_W{1'b1}};

endpackage

/* design/fihfo_div.sv */
// Iterative restoring divider: quotient = floor(elapsed * 65535 / time), elapsed < time.
module fihfo_div import fihfo_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_cnt i_elapsed,
    input  t_cnt i_time,
    output logic o_done,
    output t_opa o_quot
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_PREP = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;

    localparam int NUM_W = CNT_W + OPA_W;
    localparam int STP_W = $clog2(OPA_W);

    logic [1:0]       r_st, n_st;
    logic [STP_W-1:0] r_cnt, n_cnt;
    t_cnt             r_rem, n_rem;
    t_opa             r_quo, n_quo;  // numerator low bits shift out, quotient bits in
    logic             r_done, n_done;

    logic [NUM_W-1:0] num;
    logic [CNT_W:0]   trial;
    logic             fits;

    // elapsed * (2^16 - 1); top part is below time since elapsed < time
    assign num   = {i_elapsed, OPA_ZERO} - {{OPA_W{1'b0}}, i_elapsed};
    assign trial = {r_rem, r_quo[OPA_W-1]};
    assign fits  = trial >= {1'b0, i_time};

    always_comb begin
        n_st   = r_st;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_done = 1'b0;
        unique case (r_st)
            D_IDLE: begin
                if (i_start) begin
                    n_st = D_PREP;
                end
            end
            D_PREP: begin
                n_rem = num[NUM_W-1:OPA_W];
                n_quo = num[OPA_W-1:0];
                n_cnt = '0;
                n_st  = D_RUN;
            end
            D_RUN: begin
                n_rem = fits ? CNT_W'(trial - {1'b0, i_time}) : trial[CNT_W-1:0];
                n_quo = {r_quo[OPA_W-2:0], fits};
                n_cnt = r_cnt + STP_W'(1);
                if (r_cnt == STP_W'(OPA_W - 1)) begin
                    n_st   = D_IDLE;
                    n_done = 1'b1;
                end
            end
            default: n_st = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= D_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

/* design/fade_in_hold_fade_out_timer.sv */
// Top level of the fade-in / hold / fade-out opacity envelope timer.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------
//  in       | i_in_valid / o_in_stall   | i_cmd, i_delta
//  out      | o_out_valid / i_out_stall | o_opacity, o_phase
//  cfg      | i_cfg_wr_en               | i_cfg_index, i_cfg_wdata
//
// Start items, hold ticks and ticks that need no ratio go through the update
// and output states to the result register; fade ticks that need a ratio also
// wait on the shared restoring divider (a prep step, one quotient bit per cycle).
// Synchronous active-low reset: phase hold, full opacity, elapsed counters and
// configuration registers zero, no result valid. A stalled result holds the block
// busy until it is taken; one further item may be accepted while a result waits.
module fade_in_hold_fade_out_timer import fihfo_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_wr_en,
    input  t_idx              i_cfg_index,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    // input items
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_cmd,
    input  logic [DLT_W-1:0]  i_delta,
    // result items
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [OPA_W-1:0]  o_opacity,
    output logic [PH_W-1:0]   o_phase
);

    // sequencer
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // configuration registers
    t_cnt r_fi_time, r_hold_time, r_fo_time;
    logic r_loop;

    // envelope state
    logic [1:0]       r_state, n_state;
    t_phase           r_phase, n_phase;
    t_cnt             r_fi_el, n_fi_el;
    t_cnt             r_hold_el, n_hold_el;
    t_cnt             r_fo_el, n_fo_el;
    t_opa             r_opa, n_opa;

    // accepted item
    logic             r_cmd, n_cmd;
    logic [DLT_W-1:0] r_delta, n_delta;

    // result register
    logic             r_out_valid, n_out_valid;
    t_opa             r_out_opa, n_out_opa;
    t_phase           r_out_ph, n_out_ph;

    logic             in_acc;
    t_cnt             sel_el, sel_time, sat;
    logic [CNT_W:0]   sum;
    logic             reach;
    logic             div_start, div_done;
    t_opa             div_quot;
    t_cnt             div_el, div_time;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // one saturating add and one compare, on the counter of the current phase
    always_comb begin
        case (r_phase)
            PH_FADE_IN: begin
                sel_el   = r_fi_el;
                sel_time = r_fi_time;
            end
            PH_HOLD: begin
                sel_el   = r_hold_el;
                sel_time = r_hold_time;
            end
            default: begin
                sel_el   = r_fo_el;
                sel_time = r_fo_time;
            end
        endcase
    end

    assign sum   = {1'b0, sel_el} + {{(CNT_W + 1 - DLT_W){1'b0}}, r_delta};
    assign sat   = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    assign reach = (sat >= sel_time);

    // ratio operands follow the phase, which stays put during the division
    assign div_el   = (r_phase == PH_FADE_IN) ? r_fi_el   : r_fo_el;
    assign div_time = (r_phase == PH_FADE_IN) ? r_fi_time : r_fo_time;

    fihfo_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_elapsed (div_el),
        .i_time    (div_time),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_fi_el     = r_fi_el;
        n_hold_el   = r_hold_el;
        n_fo_el     = r_fo_el;
        n_opa       = r_opa;
        n_cmd       = r_cmd;
        n_delta     = r_delta;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_opa   = r_out_opa;
        n_out_ph    = r_out_ph;
        div_start   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = i_cmd;
                    n_delta = i_delta;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_OUT;
                if (r_cmd == CMD_START) begin
                    if (r_fi_time != '0) begin
                        n_phase = PH_FADE_IN;
                        n_opa   = OPA_ZERO;
                    end else begin
                        n_phase = PH_HOLD;
                    end
                end else begin
                    case (r_phase)
                        PH_FADE_IN: begin
                            n_fi_el = sat;
                            // zero length also lands here: sat >= 0
                            if (reach) begin
                                n_phase = PH_HOLD;
                                n_opa   = OPA_FULL;
                            end else begin
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        PH_HOLD: begin
                            if (r_hold_time != '0) begin
                                n_hold_el = sat;
                                if (reach) begin
                                    if (r_fo_time != '0) begin
                                        n_phase = PH_FADE_OUT;
                                    end else if (r_loop) begin
                                        n_fi_el   = '0;
                                        n_hold_el = '0;
                                        n_fo_el   = '0;
                                        if (r_fi_time != '0) begin
                                            n_phase = PH_FADE_IN;
                                            n_opa   = OPA_ZERO;
                                        end
                                    end else begin
                                        n_phase = PH_DONE;
                                    end
                                end
                            end
                        end
                        PH_FADE_OUT: begin
                            if (r_fo_time != '0) begin
                                n_fo_el = sat;
                                if (reach) begin
                                    // ratio clamps to full, so opacity falls to zero
                                    n_opa = OPA_ZERO;
                                    if (r_loop) begin
                                        n_fi_el   = '0;
                                        n_hold_el = '0;
                                        n_fo_el   = '0;
                                        if (r_fi_time != '0) begin
                                            n_phase = PH_FADE_IN;
                                        end else begin
                                            n_phase = PH_HOLD;
                                            n_opa   = OPA_FULL;
                                        end
                                    end else begin
                                        n_phase = PH_DONE;
                                    end
                                end else begin
                                    div_start = 1'b1;
                                    n_state   = S_DIV;
                                end
                            end
                        end
                        default: ; // finished: ticks ignored
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_opa   = (r_phase == PH_FADE_IN) ? div_quot : ~div_quot;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_opa   = r_opa;
                    n_out_ph    = r_phase;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fi_time   <= '0;
            r_hold_time <= '0;
            r_fo_time   <= '0;
            r_loop      <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_FADE_IN_TIME:  r_fi_time   <= i_cfg_wdata;
                REG_HOLD_TIME:     r_hold_time <= i_cfg_wdata;
                REG_FADE_OUT_TIME: r_fo_time   <= i_cfg_wdata;
                REG_LOOP_ENABLE:   r_loop      <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_HOLD;
            r_fi_el     <= '0;
            r_hold_el   <= '0;
            r_fo_el     <= '0;
            r_opa       <= OPA_FULL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_fi_el     <= n_fi_el;
            r_hold_el   <= n_hold_el;
            r_fo_el     <= n_fo_el;
            r_opa       <= n_opa;
            r_out_valid <= n_out_valid;
        end
        r_cmd     <= n_cmd;
        r_delta   <= n_delta;
        r_out_opa <= n_out_opa;
        r_out_ph  <= n_out_ph;
    end

    assign o_out_valid = r_out_valid;
    assign o_opacity   = r_out_opa;
    assign o_phase     = r_out_ph;

endmodule
